>>> hdl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds request and status codes, controller states and the
// command/status bundles between controller and datapath. No dependencies.
package bba_pkg;

  localparam int BLK_W     = 16;  // absolute block number width
  localparam int CNT_W     = 11;  // managed block count width
  localparam int CFG_W     = 16;  // configuration write data width
  localparam int CFG_IDX_W = 1;   // configuration register index width

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLOCK    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_DIV,
    S_FIX,
    S_RMW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic accept;     // latch the request, restart the scan counters
    logic clear;      // write one zero word of the clearing pass
    logic scan;       // issue one bitmap read and check the previous word
    logic set_full;   // report no free block
    logic set_range;  // report block number out of range
    logic div;        // estimate word index of the relative block
    logic fix;        // correct word index and bit, read the word
    logic rmw;        // update or test the addressed bit
    logic load_out;   // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_ok;
    logic span_zero;
    logic found;
    logic exhausted;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: configuration registers, span
// computation, controller and datapath. Uses bba_pkg, bba_ctrl and bba_dp.
//
// The allocator keeps a used/free bit for each block of a range that starts
// at base_block and covers blocks_in_use blocks (clipped to MAX_BLOCKS and to
// block 65535), held in a single-port-write memory of MAX_BLOCKS/WORD_BITS
// words, rounded up. Requests are handled one at a time. Allocate scans the
// bitmap one word per cycle from the lowest word; the scan stops at the first
// word with a free bit in range. Release, reserve and query go through
// accept, decode, a reciprocal multiply that finds the word index, a
// correction that reads the word, a read-modify-write and the hand-off to
// the output register. Out-of-range requests and allocates with an empty
// range go from decode straight to the hand-off. The output register lets
// the next request be accepted while a result waits. After reset a clearing
// pass writes zero to each of the MAP_WORDS words (32 by default), during
// which in_stall stays high; configuration writes are taken at any time
// (cfg_ready is always high) but must only be issued while no request is in
// flight.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [BLK_W-1:0]     in_block_number,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLK_W-1:0]     out_granted_block,
  output logic                 out_block_free,
  output logic [1:0]           out_status,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [BLK_W-1:0] base_block_r;
  logic [CNT_W-1:0] blocks_in_use_r;
  logic [BLK_W:0]   room;
  logic [BLK_W:0]   span_wide;
  logic [CNT_W-1:0] span;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_block_r    <= '0;
      blocks_in_use_r <= CNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_BLOCK:    base_block_r    <= cfg_data;
        CFG_BLOCKS_IN_USE: blocks_in_use_r <= CNT_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // clip the managed count to the table size and to the top of block space
  always_comb begin
    room      = (BLK_W + 1)'(1 << BLK_W) - {1'b0, base_block_r};
    span_wide = (BLK_W + 1)'(blocks_in_use_r);
    if (span_wide > (BLK_W + 1)'(MAX_BLOCKS)) begin
      span_wide = (BLK_W + 1)'(MAX_BLOCKS);
    end
    if (span_wide > room) begin
      span_wide = room;
    end
    span = CNT_W'(span_wide);
  end

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_block_number   (in_block_number),
    .base_block        (base_block_r),
    .span              (span),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_block_free    (out_block_free),
    .out_status        (out_status)
  );

endmodule

>>> hdl/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Sequences clearing pass, scan and read-modify-write; uses bba_pkg.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.op == OP_ALLOC) begin
          if (sts.span_zero) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (!sts.range_ok) begin
          cmd.set_range = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.exhausted) begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        cmd.rmw   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bba_dp.sv
// Datapath of the bitmap block allocator: bitmap memory, scan counters,
// word index unit, result and output registers. Uses bba_pkg.
module bba_dp
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  logic [1:0]       in_op,
  input  logic [BLK_W-1:0] in_block_number,
  input  logic [BLK_W-1:0] base_block,
  input  logic [CNT_W-1:0] span,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [BLK_W-1:0] out_granted_block,
  output logic             out_block_free,
  output logic [1:0]       out_status
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BI_W      = $clog2(WORD_BITS);
  localparam int BASE_W    = CNT_W + 1;
  // reciprocal of the word size, exact to within one after truncation
  localparam int SH        = CNT_W + 1;
  localparam int RECIP     = (1 << SH) / WORD_BITS;
  localparam int RCP_W     = SH - 2;
  localparam int PROD_W    = CNT_W + RCP_W;

  logic [WORD_BITS-1:0] mem [0:MAP_WORDS-1];

  op_t                  op_r;
  logic [CNT_W-1:0]     rel_r;
  logic                 range_ok_r;
  logic [CNT_W-1:0]     span_r;
  logic [CNT_W-1:0]     q_est_r;
  logic [WA_W-1:0]      word_addr_r;
  logic [BI_W-1:0]      bit_r;
  logic [WA_W-1:0]      iss_addr_r;
  logic [BASE_W-1:0]    iss_base_r;
  logic                 eval_v_r;
  logic [WA_W-1:0]      eval_addr_r;
  logic [BASE_W-1:0]    eval_base_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [BLK_W-1:0]     granted_res_r;
  logic                 free_res_r;
  status_t              status_res_r;
  logic                 out_valid_r;
  logic [BLK_W-1:0]     out_granted_r;
  logic                 out_free_r;
  status_t              out_status_r;

  logic [BLK_W:0]       diff;
  logic                 in_range;
  logic [PROD_W-1:0]    prod;
  logic [CNT_W-1:0]     q_times_w;
  logic [CNT_W-1:0]     fix_rem;
  logic [CNT_W-1:0]     fix_q;
  logic [BI_W-1:0]      fix_bit;
  logic [BASE_W-1:0]    rem_bits;
  logic [WORD_BITS-1:0] avail_mask;
  logic [WORD_BITS-1:0] free_vec;
  logic                 any_free;
  logic [BI_W-1:0]      pick;
  logic                 last_word;
  logic                 iss_ok;
  logic                 found;
  logic                 exhausted;
  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 out_take;

  // range check of the incoming block number
  assign diff     = {1'b0, in_block_number} - {1'b0, base_block};
  assign in_range = !diff[BLK_W] && (diff[BLK_W-1:0] < BLK_W'(span));

  // word index: reciprocal estimate, then one correction step
  assign prod = PROD_W'(rel_r) * PROD_W'(RECIP);

  always_comb begin
    q_times_w = CNT_W'(q_est_r * CNT_W'(WORD_BITS));
    fix_rem   = rel_r - q_times_w;
    if (fix_rem >= CNT_W'(WORD_BITS)) begin
      fix_q   = q_est_r + CNT_W'(1);
      fix_bit = BI_W'(fix_rem - CNT_W'(WORD_BITS));
    end else begin
      fix_q   = q_est_r;
      fix_bit = BI_W'(fix_rem);
    end
  end

  // first-fit search within the word under evaluation
  always_comb begin
    rem_bits = BASE_W'(span_r) - eval_base_r;
    for (int b = 0; b < WORD_BITS; b++) begin
      avail_mask[b] = BASE_W'(b) < rem_bits;
    end
    free_vec = ~rd_data_r & avail_mask;
    any_free = |free_vec;
    pick     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        pick = BI_W'(b);
      end
    end
  end

  assign last_word = (eval_base_r + BASE_W'(WORD_BITS)) >= BASE_W'(span_r);
  assign iss_ok    = iss_base_r < BASE_W'(span_r);
  assign found     = eval_v_r && any_free;
  assign exhausted = eval_v_r && !any_free && last_word;
  assign bit_mask  = WORD_BITS'(1) << bit_r;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss_addr_r;
    wr_en   = 1'b0;
    wr_addr = iss_addr_r;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end
    if (cmd.scan) begin
      rd_en = iss_ok;
      if (found) begin
        wr_en   = 1'b1;
        wr_addr = eval_addr_r;
        wr_data = rd_data_r | (WORD_BITS'(1) << pick);
      end
    end
    if (cmd.fix) begin
      rd_en   = 1'b1;
      rd_addr = WA_W'(fix_q);
    end
    if (cmd.rmw) begin
      wr_addr = word_addr_r;
      case (op_r)
        OP_RELEASE: begin
          wr_en   = 1'b1;
          wr_data = rd_data_r & ~bit_mask;
        end
        OP_RESERVE: begin
          wr_en   = 1'b1;
          wr_data = rd_data_r | bit_mask;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_addr_r <= '0;
      iss_base_r <= '0;
      eval_v_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        iss_addr_r <= iss_addr_r + WA_W'(1);
      end
      if (cmd.accept) begin
        iss_addr_r <= '0;
        iss_base_r <= '0;
        eval_v_r   <= 1'b0;
      end
      if (cmd.scan) begin
        eval_v_r <= iss_ok;
        if (iss_ok) begin
          iss_addr_r <= iss_addr_r + WA_W'(1);
          iss_base_r <= iss_base_r + BASE_W'(WORD_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r          <= op_t'(in_op);
      rel_r         <= CNT_W'(diff);
      range_ok_r    <= in_range;
      span_r        <= span;
      granted_res_r <= '0;
      free_res_r    <= 1'b0;
      status_res_r  <= ST_OK;
    end
    if (cmd.scan) begin
      eval_addr_r <= iss_addr_r;
      eval_base_r <= iss_base_r;
      if (found) begin
        granted_res_r <= base_block + BLK_W'(eval_base_r) + BLK_W'(pick);
      end
      if (exhausted) begin
        status_res_r <= ST_FULL;
      end
    end
    if (cmd.set_full) begin
      status_res_r <= ST_FULL;
    end
    if (cmd.set_range) begin
      status_res_r <= ST_RANGE;
    end
    if (cmd.div) begin
      q_est_r <= CNT_W'(prod >> SH);
    end
    if (cmd.fix) begin
      word_addr_r <= WA_W'(fix_q);
      bit_r       <= fix_bit;
    end
    if (cmd.rmw && op_r == OP_QUERY) begin
      free_res_r <= !rd_data_r[bit_r];
    end
  end

  // output register
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted_r <= granted_res_r;
      out_free_r    <= free_res_r;
      out_status_r  <= status_res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_granted_r;
  assign out_block_free    = out_free_r;
  assign out_status        = out_status_r;

  assign sts.op        = op_r;
  assign sts.range_ok  = range_ok_r;
  assign sts.span_zero = (span_r == '0);
  assign sts.found     = found;
  assign sts.exhausted = exhausted;
  assign sts.clr_last  = (iss_addr_r == WA_W'(MAP_WORDS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  a_eval_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    eval_v_r |-> eval_base_r < BASE_W'(span_r))
    else $error("scan evaluates a word beyond the managed range");

  a_bit_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |=> BASE_W'(bit_r) < BASE_W'(WORD_BITS))
    else $error("corrected bit index falls outside the word");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwrites an untaken output");

  a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_granted_r == '0)
    else $error("full allocate reports a granted block");

endmodule
